FILE: hdl/fid_pkg.sv
// shared constants and types for the filter id decoder
package fid_pkg;

    localparam int DIM_W   = 7;
    localparam int KIND_W  = 3;
    localparam int NUM_W   = 15;
    localparam int BLOCK_W = 10;
    localparam int TNEXT_W = 8;

    localparam int KEY_WIDTH_DEF  = 32;
    localparam int BAND_COUNT_DEF = 33;

    typedef struct packed {
        logic [KIND_W-1:0] count;
        logic [KIND_W-1:0] kind;
    } shape_info_t;

endpackage

FILE: hdl/fid_shape.sv
// shape type presence, count and selection for one time length and band width
module fid_shape (
    input  logic [fid_pkg::DIM_W-1:0]  t_len,
    input  logic [fid_pkg::DIM_W-1:0]  w_len,
    input  logic [fid_pkg::KIND_W-1:0] k_sel,
    output fid_pkg::shape_info_t       info
);
    import fid_pkg::*;

    logic [5:0] present;

    always_comb
    begin
        present[0] = 1'b1;
        present[1] = (t_len > DIM_W'(1));
        present[2] = (w_len > DIM_W'(1));
        present[3] = (t_len > DIM_W'(1)) && (w_len > DIM_W'(1));
        present[4] = (t_len > DIM_W'(3));
        present[5] = (w_len > DIM_W'(3));
    end

    // walk the six types in order, pick the k-th present one
    always_comb
    begin
        logic [KIND_W-1:0] run;
        run = '0;
        info.kind = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (present[i])
            begin
                run = run + KIND_W'(1);
                if (run == k_sel && info.kind == '0)
                begin
                    info.kind = KIND_W'(i + 1);
                end
            end
        end
        info.count = run;
    end

endmodule

FILE: hdl/fid_sub_unit.sv
// shared compare and subtract unit
module fid_sub_unit (
    input  logic [fid_pkg::NUM_W-1:0] a,
    input  logic [fid_pkg::NUM_W-1:0] b,
    output logic [fid_pkg::NUM_W-1:0] diff,
    output logic                      a_gt_b
);
    import fid_pkg::*;

    logic [NUM_W:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[NUM_W-1:0];
    // a > b when a - b neither borrows nor is zero
    assign a_gt_b = !wide[NUM_W] && (wide[NUM_W-1:0] != '0);

endmodule

FILE: hdl/filter_id_decoder.sv
// top level of the filter id decoder: sequencer around a shared subtract unit
//
// usage
//   input channel: in_valid / in_ready with filter_number, a one-based filter index
//   output channel: out_valid / out_ready with time_length, band_width, start_band,
//   shape_kind and not_found; one result item for every input item
//   in_ready is high only while the block is idle, so one item is decoded at a time
//
// sequence
//   the item walks the enumeration one (time length, band width) block per cycle,
//   subtracting the block's filter count from the remaining index, then steps
//   through start bands one per cycle inside the matching block
//   a zero index goes straight from idle to the result, marked not found
//   the pace is set by the single compare and subtract unit, used once per cycle
//
// reset and stalls
//   rst_n clears the sequencer to idle with no result pending
//   a finished result holds in the output registers until out_ready takes it;
//   no new item is accepted until then, the next one in the cycle after it leaves
module filter_id_decoder #(
    parameter int KEY_WIDTH  = fid_pkg::KEY_WIDTH_DEF,
    parameter int BAND_COUNT = fid_pkg::BAND_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fid_pkg::NUM_W-1:0]   filter_number,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [fid_pkg::DIM_W-1:0]   time_length,
    output logic [fid_pkg::DIM_W-1:0]   band_width,
    output logic [fid_pkg::DIM_W-1:0]   start_band,
    output logic [fid_pkg::KIND_W-1:0]  shape_kind,
    output logic                        not_found
);
    import fid_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BLOCK = 2'd1;
    localparam logic [1:0] ST_SLOT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [DIM_W-1:0]   BAND_LAST = DIM_W'(BAND_COUNT);
    localparam logic [TNEXT_W-1:0] KEY_LIMIT = TNEXT_W'(KEY_WIDTH);

    logic [1:0]        state_reg, state_next;
    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  t_reg, t_next;
    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  s_reg, s_next;

    logic [DIM_W-1:0]  res_t_reg, res_t_next;
    logic [DIM_W-1:0]  res_w_reg, res_w_next;
    logic [DIM_W-1:0]  res_s_reg, res_s_next;
    logic [KIND_W-1:0] res_k_reg, res_k_next;
    logic              res_nf_reg, res_nf_next;

    shape_info_t       shape;
    logic [DIM_W-1:0]  starts;
    logic [BLOCK_W-1:0] block_size;
    logic [NUM_W-1:0]  operand;
    logic [NUM_W-1:0]  diff;
    logic              rem_gt;

    logic [TNEXT_W-1:0] t_wide;
    logic [TNEXT_W-1:0] triple;
    logic [TNEXT_W-1:0] rounded;
    logic [TNEXT_W-1:0] evened;
    logic [TNEXT_W-1:0] t_plus;
    logic [TNEXT_W-1:0] t_after;

    // shape count for the current block, and kind pick from the low remainder bits
    fid_shape u_shape (
        .t_len (t_reg),
        .w_len (w_reg),
        .k_sel (rem_reg[KIND_W-1:0]),
        .info  (shape)
    );

    fid_sub_unit u_sub (
        .a      (rem_reg),
        .b      (operand),
        .diff   (diff),
        .a_gt_b (rem_gt)
    );

    // filters in one block: shape count times number of start bands
    assign starts     = BAND_LAST - w_reg + DIM_W'(1);
    assign block_size = BLOCK_W'(shape.count) * BLOCK_W'(starts);

    // next time length: r = (3t + 1) / 2, rounded up to even, at least t + 1
    assign t_wide  = TNEXT_W'(t_reg);
    assign triple  = (t_wide << 1) + t_wide + TNEXT_W'(1);
    assign rounded = triple >> 1;
    assign evened  = rounded + TNEXT_W'(rounded[0]);
    assign t_plus  = t_wide + TNEXT_W'(1);
    assign t_after = (evened > t_plus) ? evened : t_plus;

    // the unit compares against the block size while skipping blocks,
    // and against the shape count while stepping start bands
    always_comb
    begin
        if (state_reg == ST_SLOT)
        begin
            operand = NUM_W'(shape.count);
        end
        else
        begin
            operand = NUM_W'(block_size);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        t_next      = t_reg;
        w_next      = w_reg;
        s_next      = s_reg;
        res_t_next  = res_t_reg;
        res_w_next  = res_w_reg;
        res_s_next  = res_s_reg;
        res_k_next  = res_k_reg;
        res_nf_next = res_nf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next    = filter_number;
                    t_next      = DIM_W'(1);
                    w_next      = DIM_W'(1);
                    s_next      = DIM_W'(1);
                    res_t_next  = '0;
                    res_w_next  = '0;
                    res_s_next  = '0;
                    res_k_next  = '0;
                    res_nf_next = 1'b1;
                    // index zero names no filter
                    if (filter_number == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_BLOCK;
                    end
                end
            end

            ST_BLOCK:
            begin
                if (rem_gt)
                begin
                    // target lies past this block: skip it whole
                    rem_next = diff;
                    if (w_reg == BAND_LAST)
                    begin
                        w_next = DIM_W'(1);
                        t_next = t_after[DIM_W-1:0];
                        if (t_after >= KEY_LIMIT)
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        w_next = w_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_SLOT;
                end
            end

            ST_SLOT:
            begin
                if (rem_gt)
                begin
                    rem_next = diff;
                    s_next   = s_reg + DIM_W'(1);
                end
                else
                begin
                    res_t_next  = t_reg;
                    res_w_next  = w_reg;
                    res_s_next  = s_reg;
                    res_k_next  = shape.kind;
                    res_nf_next = 1'b0;
                    state_next  = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working and result registers carry no reset
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        t_reg      <= t_next;
        w_reg      <= w_next;
        s_reg      <= s_next;
        res_t_reg  <= res_t_next;
        res_w_reg  <= res_w_next;
        res_s_reg  <= res_s_next;
        res_k_reg  <= res_k_next;
        res_nf_reg <= res_nf_next;
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign time_length = res_t_reg;
    assign band_width  = res_w_reg;
    assign start_band  = res_s_reg;
    assign shape_kind  = res_k_reg;
    assign not_found   = res_nf_reg;

endmodule

FILE: hdl/fid_checker.sv
// port-level checks for the filter id decoder, bound to the top level
module fid_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [fid_pkg::DIM_W-1:0]   time_length,
    input logic [fid_pkg::DIM_W-1:0]   band_width,
    input logic [fid_pkg::DIM_W-1:0]   start_band,
    input logic [fid_pkg::KIND_W-1:0]  shape_kind,
    input logic                        not_found
);
    import fid_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(time_length)
            && $stable(band_width) && $stable(start_band)
            && $stable(shape_kind) && $stable(not_found))
        else $error("stalled result changed");

    // one item at a time: never ready while a result is pending
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("ready while result pending");

    // a miss carries all-zero fields
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_found |-> time_length == '0 && band_width == '0
            && start_band == '0 && shape_kind == '0)
        else $error("miss with non-zero fields");

    // a hit carries non-zero fields and a type whose condition holds (type 4 not checked)
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !not_found |-> time_length != '0 && band_width != '0
            && start_band != '0 && shape_kind != '0 && shape_kind <= KIND_W'(6)
            && (shape_kind != KIND_W'(2) || time_length > DIM_W'(1))
            && (shape_kind != KIND_W'(3) || band_width > DIM_W'(1))
            && (shape_kind != KIND_W'(5) || time_length > DIM_W'(3))
            && (shape_kind != KIND_W'(6) || band_width > DIM_W'(3)))
        else $error("hit with impossible type");

endmodule

bind filter_id_decoder fid_checker u_fid_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .time_length (time_length),
    .band_width  (band_width),
    .start_band  (start_band),
    .shape_kind  (shape_kind),
    .not_found   (not_found)
);
